### hw/rtl/bfsa_pkg.sv
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared types, constants and the controller/datapath command interface of
// the best-fit segment allocator.
// ----------------------------------------------------------------------------
package bfsa_pkg;

	localparam int FREE_SLOTS   = 256;
	localparam int SLOT_W       = $clog2(FREE_SLOTS);
	localparam int LINK_W       = SLOT_W + 1;
	localparam int HEADER_BYTES = 8;
	localparam int EXP_CAP      = 30;
	localparam int REQ_W        = 24;
	localparam int SIZE_W       = 32;
	localparam int EXP_W        = 5;
	localparam int GROW_W       = 31;
	localparam int STAT_W       = 2;
	localparam int CFG_IDX_W    = 1;

	localparam logic [LINK_W-1:0] NIL_SLOT = LINK_W'(FREE_SLOTS);

	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_GROW_EXP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT       = 1'b1;

	localparam logic [STAT_W-1:0] ST_FREE_LIST = 2'd0;
	localparam logic [STAT_W-1:0] ST_GROWN     = 2'd1;
	localparam logic [STAT_W-1:0] ST_DROPPED   = 2'd2;
	localparam logic [STAT_W-1:0] ST_OOM       = 2'd3;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [LINK_W-1:0] link_t;

	typedef enum logic [19:0] {
		S_IDLE    = 20'h00001,
		S_FIRST   = 20'h00002,
		S_SRCH_RD = 20'h00004,
		S_SRCH_EV = 20'h00008,
		S_UNLINK  = 20'h00010,
		S_FIT     = 20'h00020,
		S_GROW    = 20'h00040,
		S_GROW_CK = 20'h00080,
		S_FREE_RD = 20'h00100,
		S_FREE_EV = 20'h00200,
		S_INS_RD  = 20'h00400,
		S_INS_EV  = 20'h00800,
		S_INS_WR  = 20'h01000,
		S_INS_FIX = 20'h02000,
		S_RESP    = 20'h04000,
		S_UNL_P   = 20'h08000,
		S_UNL_N   = 20'h10000,
		S_CLEAR   = 20'h20000,
		S_CLR_WT  = 20'h40000,
		S_SPARE   = 20'h80000
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		state_t st;
	} bfsa_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic first_ok;
		logic hit;
		logic walk_end;
		logic exact;
		logic grow_ok;
		logic slot_free;
		logic scan_end;
		logic ins_stop;
		logic clr_done;
		logic from_fit;
	} bfsa_stat_t;

endpackage

### hw/rtl/best_fit_segment_allocator_unit.sv
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_unit
// Best-fit allocator over a size-sorted free list with power-of-two growth.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  s_axis    in   tvalid/tready    tdata[23:0] req_size
//  m_axis    out  tvalid/tready    tdata[64:0] block_addr, status, grow_bytes
//  cfg       in   cfg_valid/ready  cfg_index, cfg_data
//
// One request at a time. A request passes through a read state and an evaluate
// state for each list entry visited in the best-fit walk, for each entry in the
// sorted insert and for each slot in the free-slot scan, set by the one read
// port of the slot memories. After reset a clearing pass zeroes the size memory
// before the first request is taken. A result waits in its register until taken;
// the next request is taken after that.
module best_fit_segment_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [23:0] req_size
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [31:0] block_addr, [33:32] status,
	                                    // [64:34] grow_bytes, [71:65] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import bfsa_pkg::*;

	bfsa_cmd_t         cmd;
	bfsa_stat_t        stat;
	logic              start, started, resp_taken;
	logic [EXP_W-1:0]  init_exp_q;
	logic [SIZE_W-1:0] limit_q;
	logic [SIZE_W-1:0] block_addr;
	logic [STAT_W-1:0] status;
	logic [GROW_W-1:0] grow_bytes;

	assign s_axis_tready = (cmd.st == S_IDLE);
	assign start         = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (cmd.st == S_RESP);
	assign resp_taken    = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = {7'd0, grow_bytes, status, block_addr};
	assign cfg_ready     = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_exp_q <= EXP_W'(8);
			limit_q    <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_INITIAL_GROW_EXP: init_exp_q <= cfg_data[EXP_W-1:0];
				CFG_HEAP_LIMIT:       limit_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	bfsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .started(started),
		.resp_taken(resp_taken), .stat(stat), .cmd(cmd));

	bfsa_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .start(start),
		.req_size(s_axis_tdata), .init_exp(init_exp_q), .heap_limit(limit_q),
		.stat(stat), .started(started), .block_addr(block_addr),
		.status(status), .grow_bytes(grow_bytes));

	// Out of memory answers carry a zero address
	a_oom_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == ST_OOM |-> block_addr == '0)
		else $error("oom with nonzero address");

	// No request is taken while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready while result pending");

	// A request leaves the idle state at once
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !s_axis_tready)
		else $error("request not started");

endmodule

### hw/rtl/bfsa_ram.sv
// ----------------------------------------------------------------------------
// bfsa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/bfsa_ctrl.sv
// ----------------------------------------------------------------------------
// bfsa_ctrl
// Sequencer of the allocator: clearing pass after reset, first-block setup,
// list walk, unlink, growth, free-slot scan, sorted insert and the response.
// ----------------------------------------------------------------------------
module bfsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                started,
	input  logic                resp_taken,
	input  bfsa_pkg::bfsa_stat_t stat,
	output bfsa_pkg::bfsa_cmd_t  cmd
);
	import bfsa_pkg::*;

	state_t state_q, state_d;

	assign cmd.st = state_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:   if (stat.clr_done) state_d = S_IDLE;
			S_IDLE:    if (start) state_d = started ? S_SRCH_RD : S_FIRST;
			S_FIRST:   state_d = stat.first_ok ? S_INS_RD : S_SRCH_RD;
			S_SRCH_RD: state_d = stat.walk_end ? S_GROW : S_SRCH_EV;
			S_SRCH_EV: state_d = stat.hit ? S_UNLINK : S_SRCH_RD;
			S_UNLINK:  state_d = S_UNL_P;
			S_UNL_P:   state_d = S_UNL_N;
			S_UNL_N:   state_d = S_FIT;
			S_FIT:     state_d = stat.exact ? S_RESP : S_INS_RD;
			S_GROW:    state_d = S_GROW_CK;
			S_GROW_CK: begin
				if (!stat.grow_ok) state_d = S_RESP;
				else if (stat.exact) state_d = S_RESP;
				else state_d = S_FREE_RD;
			end
			S_FREE_RD: state_d = S_FREE_EV;
			S_FREE_EV: begin
				if (stat.slot_free) state_d = S_INS_RD;
				else if (stat.scan_end) state_d = S_RESP;
				else state_d = S_FREE_RD;
			end
			S_INS_RD:  state_d = S_INS_EV;
			S_INS_EV:  state_d = stat.ins_stop ? S_INS_WR : S_INS_RD;
			S_INS_WR:  state_d = S_INS_FIX;
			S_INS_FIX: state_d = stat.from_fit ? S_RESP : S_SRCH_RD;
			S_RESP:    if (resp_taken) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hw/rtl/bfsa_dp.sv
// ----------------------------------------------------------------------------
// bfsa_dp
// Datapath of the allocator: slot memories, list head, heap pointer, growth
// exponent, walk cursors and the response register.
// ----------------------------------------------------------------------------
module bfsa_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bfsa_pkg::bfsa_cmd_t                cmd,
	input  logic                               start,
	input  logic [bfsa_pkg::REQ_W-1:0]         req_size,
	input  logic [bfsa_pkg::EXP_W-1:0]         init_exp,
	input  logic [bfsa_pkg::SIZE_W-1:0]        heap_limit,
	output bfsa_pkg::bfsa_stat_t               stat,
	output logic                               started,
	output logic [bfsa_pkg::SIZE_W-1:0]        block_addr,
	output logic [bfsa_pkg::STAT_W-1:0]        status,
	output logic [bfsa_pkg::GROW_W-1:0]        grow_bytes
);
	import bfsa_pkg::*;

	// Memories: size, start, next, prev
	logic                we_sz, we_st, we_nx, we_pv;
	slot_t               wa_sz, wa_st, wa_nx, wa_pv;
	logic [SIZE_W-1:0]   wd_sz, wd_st;
	link_t               wd_nx, wd_pv;
	slot_t               ra;
	logic [SIZE_W-1:0]   rd_sz, rd_st;
	link_t               rd_nx, rd_pv;

	bfsa_ram #(.WIDTH(SIZE_W), .DEPTH(FREE_SLOTS)) u_size (
		.clk(clk), .we(we_sz), .waddr(wa_sz), .wdata(wd_sz), .raddr(ra), .rdata(rd_sz));
	bfsa_ram #(.WIDTH(SIZE_W), .DEPTH(FREE_SLOTS)) u_start (
		.clk(clk), .we(we_st), .waddr(wa_st), .wdata(wd_st), .raddr(ra), .rdata(rd_st));
	bfsa_ram #(.WIDTH(LINK_W), .DEPTH(FREE_SLOTS)) u_next (
		.clk(clk), .we(we_nx), .waddr(wa_nx), .wdata(wd_nx), .raddr(ra), .rdata(rd_nx));
	bfsa_ram #(.WIDTH(LINK_W), .DEPTH(FREE_SLOTS)) u_prev (
		.clk(clk), .we(we_pv), .waddr(wa_pv), .wdata(wd_pv), .raddr(ra), .rdata(rd_pv));

	link_t             head_q, cur_q, prv_q, scan_q;
	slot_t             tgt_q, fnd_q;
	logic [SIZE_W-1:0] tsize_q, tstart_q, fstart_q, top_q;
	link_t             fprev_q, fnext_q;
	logic [EXP_W-1:0]  exp_q, gexp_q;
	logic [REQ_W:0]    need_q;
	logic [32:0]       taken_q;
	logic              started_q, from_fit_q;
	logic [STAT_W-1:0] stat_q;
	logic [SIZE_W-1:0] addr_q;
	link_t             clr_q;
	logic [32:0]       blk, sum;
	logic [SIZE_W:0]   rem_fit, rem_grow;
	logic [EXP_W-1:0]  e_cap;
	logic [EXP_W-1:0]  need_exp;

	assign started    = started_q;
	assign block_addr = addr_q;
	assign status     = stat_q;
	assign grow_bytes = (taken_q > 33'h07FFFFFFF) ? GROW_W'(31'h7FFFFFFF)
		: taken_q[GROW_W-1:0];

	assign e_cap   = (init_exp > EXP_W'(EXP_CAP)) ? EXP_W'(EXP_CAP) : init_exp;
	assign blk     = 33'd1 << ((cmd.st == S_FIRST) ? e_cap : gexp_q);
	assign sum     = {1'b0, top_q} + blk;
	assign rem_fit = {1'b0, rd_sz} - (SIZE_W+1)'(need_q);
	assign rem_grow = blk[SIZE_W:0] - (SIZE_W+1)'(need_q);

	// Smallest exponent whose block holds the need
	always_comb begin
		need_exp = EXP_W'(EXP_CAP);
		for (int i = EXP_CAP; i >= 0; i--) begin
			if ((33'd1 << i) >= 33'(need_q)) need_exp = EXP_W'(i);
		end
	end

	// Status toward the controller
	always_comb begin
		stat.first_ok  = (sum <= {1'b0, heap_limit});
		stat.walk_end  = cur_q[SLOT_W];
		stat.hit       = ({1'b0, rd_sz} >= (SIZE_W+1)'(need_q));
		stat.exact     = (cmd.st == S_FIT) ? (tsize_q == '0) : (rem_grow == '0);
		stat.grow_ok   = (blk >= 33'(need_q)) && (sum <= {1'b0, heap_limit});
		stat.slot_free = (rd_sz == '0);
		stat.scan_end  = (scan_q == NIL_SLOT - 1'b1);
		stat.ins_stop  = cur_q[SLOT_W] || (rd_sz > tsize_q);
		stat.clr_done  = (clr_q == NIL_SLOT);
		stat.from_fit  = from_fit_q;
	end

	// Read address
	always_comb begin
		ra = cur_q[SLOT_W-1:0];
		case (cmd.st)
			S_FREE_RD: ra = scan_q[SLOT_W-1:0];
			S_SRCH_RD, S_SRCH_EV, S_INS_RD: ra = cur_q[SLOT_W-1:0];
			default:   ra = fnd_q;
		endcase
	end

	// Write ports
	always_comb begin
		we_sz = 1'b0; wa_sz = tgt_q; wd_sz = tsize_q;
		we_st = 1'b0; wa_st = tgt_q; wd_st = tstart_q;
		we_nx = 1'b0; wa_nx = tgt_q; wd_nx = cur_q;
		we_pv = 1'b0; wa_pv = tgt_q; wd_pv = prv_q;
		case (cmd.st)
			S_CLEAR: begin
				we_sz = !clr_q[SLOT_W]; wa_sz = clr_q[SLOT_W-1:0]; wd_sz = '0;
			end
			S_UNL_P: begin
				we_nx = !fprev_q[SLOT_W]; wa_nx = fprev_q[SLOT_W-1:0]; wd_nx = fnext_q;
			end
			S_UNL_N: begin
				we_pv = !fnext_q[SLOT_W]; wa_pv = fnext_q[SLOT_W-1:0]; wd_pv = fprev_q;
			end
			S_FIT: begin
				we_sz = tsize_q == '0; wa_sz = fnd_q; wd_sz = '0;
			end
			S_INS_WR: begin
				we_sz = 1'b1; we_st = 1'b1; we_nx = 1'b1; we_pv = 1'b1;
			end
			S_INS_FIX: begin
				we_nx = !prv_q[SLOT_W]; wa_nx = prv_q[SLOT_W-1:0]; wd_nx = {1'b0, tgt_q};
				we_pv = !cur_q[SLOT_W]; wa_pv = cur_q[SLOT_W-1:0]; wd_pv = {1'b0, tgt_q};
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NIL_SLOT; started_q <= 1'b0; exp_q <= '0; top_q <= '0;
			clr_q <= '0; cur_q <= NIL_SLOT; prv_q <= NIL_SLOT; scan_q <= '0;
			from_fit_q <= 1'b0;
		end else begin
			case (cmd.st)
				S_CLEAR: clr_q <= clr_q + 1'b1;
				S_IDLE: if (start) begin
					cur_q <= head_q;
					from_fit_q <= 1'b0;
				end
				S_FIRST: begin
					started_q <= 1'b1;
					if (stat.first_ok) begin
						top_q <= sum[SIZE_W-1:0];
						exp_q <= (e_cap == EXP_W'(EXP_CAP)) ? e_cap : e_cap + 1'b1;
						cur_q <= head_q; prv_q <= NIL_SLOT;
						from_fit_q <= 1'b0;
					end else begin
						exp_q <= e_cap;
					end
				end
				S_SRCH_EV: if (!stat.hit) cur_q <= rd_nx;
				S_UNLINK: begin
					if (rd_pv[SLOT_W]) head_q <= rd_nx;
				end
				S_FIT: begin
					cur_q <= head_q; prv_q <= NIL_SLOT; from_fit_q <= 1'b1;
				end
				S_GROW_CK: if (stat.grow_ok) begin
					top_q <= sum[SIZE_W-1:0];
					exp_q <= (gexp_q == EXP_W'(EXP_CAP)) ? gexp_q : gexp_q + 1'b1;
					scan_q <= '0;
				end
				S_FREE_EV: begin
					if (stat.slot_free) begin
						cur_q <= head_q; prv_q <= NIL_SLOT; from_fit_q <= 1'b1;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_INS_EV: if (!stat.ins_stop) begin
					prv_q <= cur_q; cur_q <= rd_nx;
				end
				S_INS_WR: if (prv_q[SLOT_W]) head_q <= {1'b0, tgt_q};
				S_INS_FIX: if (!from_fit_q) begin
					cur_q <= head_q;
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (cmd.st)
			S_IDLE: if (start) begin
				need_q <= {1'b0, req_size} + (REQ_W+1)'(HEADER_BYTES);
				taken_q <= '0;
			end
			S_FIRST: if (stat.first_ok) begin
				tgt_q <= '0; tsize_q <= blk[SIZE_W-1:0]; tstart_q <= top_q;
				taken_q <= blk;
			end
			S_SRCH_EV: if (stat.hit) begin
				fnd_q <= cur_q[SLOT_W-1:0];
				tsize_q <= rem_fit[SIZE_W-1:0];
				fstart_q <= rd_st;
			end
			S_UNLINK: begin
				fprev_q <= rd_pv; fnext_q <= rd_nx;
				addr_q <= fstart_q + SIZE_W'(HEADER_BYTES);
				tstart_q <= fstart_q + SIZE_W'(need_q);
				tgt_q <= fnd_q;
				stat_q <= ST_FREE_LIST;
			end
			S_GROW: begin
				// raise the exponent until the block holds the need
				gexp_q <= (need_exp > exp_q) ? need_exp : exp_q;
			end
			S_GROW_CK: begin
				if (!stat.grow_ok) begin
					stat_q <= ST_OOM; addr_q <= '0;
				end else begin
					stat_q <= ST_GROWN;
					addr_q <= top_q + SIZE_W'(HEADER_BYTES);
					tstart_q <= top_q + SIZE_W'(need_q);
					tsize_q <= rem_grow[SIZE_W-1:0];
					taken_q <= taken_q + blk;
				end
			end
			S_FREE_EV: begin
				if (stat.slot_free) tgt_q <= scan_q[SLOT_W-1:0];
				else if (stat.scan_end) stat_q <= ST_DROPPED;
			end
			default: ;
		endcase
	end

endmodule

### tb/sv/best_fit_segment_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_unit_tb
// Self-checking bench for the best-fit allocator. It sends size requests,
// keeps its own copy of the free list, bump pointer and growth exponent,
// and compares each answer field by field. It also steps through several
// growth and limit settings, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module best_fit_segment_allocator_unit_tb;
	import bfsa_pkg::*;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int LONG_HOLD       = 400;

	typedef struct {
		logic [REQ_W-1:0] size;
		bit               drain_first;
	} alloc_req_t;

	typedef struct {
		logic [31:0]       addr;
		logic [STAT_W-1:0] status;
		logic [GROW_W-1:0] grown;
	} alloc_resp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	alloc_req_t  pending_reqs[$];
	alloc_resp_t expected_allocs[$];
	int          error_count = 0;
	int          gap_left = 0;
	int          hold_left = 0;
	bit          no_gaps = 1'b0;
	bit          long_hold_req = 1'b0;
	int          idle_cycles = 0;

	// Allocator shadow state
	logic [31:0] sh_size[FREE_SLOTS];
	logic [31:0] sh_start[FREE_SLOTS];
	int          sh_next[FREE_SLOTS];
	int          sh_prev[FREE_SLOTS];
	int          sh_head;
	int          sh_exp;
	logic [31:0] sh_top;
	bit          sh_started;
	int          sh_init_exp;
	logic [31:0] sh_limit;

	best_fit_segment_allocator_unit u_dut (.*);

	always #5 clk = ~clk;

	function automatic int cap_exp(int e);
		return (e > EXP_CAP) ? EXP_CAP : e;
	endfunction

	function automatic void list_remove(int s);
		int p, n;
		p = sh_prev[s];
		n = sh_next[s];
		if (p < FREE_SLOTS) sh_next[p] = n;
		else sh_head = (n < FREE_SLOTS) ? n : FREE_SLOTS;
		if (n < FREE_SLOTS) sh_prev[n] = p;
	endfunction

	function automatic void list_insert(int s);
		int cur, prv, steps;
		cur = sh_head;
		prv = FREE_SLOTS;
		steps = 0;
		while (cur < FREE_SLOTS && steps < FREE_SLOTS && sh_size[cur] <= sh_size[s]) begin
			prv = cur;
			cur = sh_next[cur];
			steps++;
		end
		if (cur >= FREE_SLOTS) cur = FREE_SLOTS;
		sh_prev[s] = prv;
		sh_next[s] = cur;
		if (prv < FREE_SLOTS) sh_next[prv] = s; else sh_head = s;
		if (cur < FREE_SLOTS) sh_prev[cur] = s;
	endfunction

	// Work out the answer to one request and advance the shadow state
	function automatic alloc_resp_t predict_alloc(logic [REQ_W-1:0] size);
		alloc_resp_t r;
		longint need, taken, blk, rem, base;
		int e, cur, steps, found, s;
		need = longint'(size) + HEADER_BYTES;
		taken = 0;
		found = FREE_SLOTS;
		r.addr = '0;
		r.status = ST_FREE_LIST;
		if (!sh_started) begin
			e = cap_exp(sh_init_exp);
			blk = longint'(1) << e;
			sh_started = 1'b1;
			if (longint'(sh_top) + blk <= longint'(sh_limit)) begin
				sh_size[0] = blk[31:0];
				sh_start[0] = sh_top;
				list_insert(0);
				sh_top = sh_top + blk[31:0];
				taken += blk;
				sh_exp = cap_exp(e + 1);
			end else begin
				sh_exp = e;
			end
		end
		// best-fit walk
		cur = sh_head;
		for (steps = 0; cur < FREE_SLOTS && steps < FREE_SLOTS; steps++) begin
			if (longint'(sh_size[cur]) >= need) begin
				found = cur;
				break;
			end
			cur = sh_next[cur];
		end
		if (found < FREE_SLOTS) begin
			rem = longint'(sh_size[found]) - need;
			r.addr = sh_start[found] + HEADER_BYTES;
			list_remove(found);
			if (rem != 0) begin
				sh_start[found] = sh_start[found] + need[31:0];
				sh_size[found] = rem[31:0];
				list_insert(found);
			end else begin
				sh_size[found] = '0;
			end
		end else begin
			e = cap_exp(sh_exp);
			while (e < EXP_CAP && (longint'(1) << e) < need) e++;
			blk = longint'(1) << e;
			if (blk < need || longint'(sh_top) + blk > longint'(sh_limit)) begin
				r.status = ST_OOM;
			end else begin
				base = sh_top;
				rem = blk - need;
				r.addr = base[31:0] + HEADER_BYTES;
				sh_top = base[31:0] + blk[31:0];
				taken += blk;
				sh_exp = cap_exp(e + 1);
				r.status = ST_GROWN;
				if (rem != 0) begin
					for (s = 0; s < FREE_SLOTS && sh_size[s] != 0; s++) begin
					end
					if (s >= FREE_SLOTS) begin
						r.status = ST_DROPPED;
					end else begin
						sh_start[s] = base[31:0] + need[31:0];
						sh_size[s] = rem[31:0];
						list_insert(s);
					end
				end
			end
		end
		if (taken > 64'h7FFF_FFFF) taken = 64'h7FFF_FFFF;
		r.grown = taken[GROW_W-1:0];
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %0h, expected %0h", what, got, want);
		error_count++;
	endtask

	// Request driver: accept, predict, then offer the next item after its gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_allocs.push_back(predict_alloc(s_axis_tdata));
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0 && (!pending_reqs[0].drain_first ||
						(expected_allocs.size() == 0 && !s_axis_tvalid))) begin
					s_axis_tdata <= pending_reqs[0].size;
					s_axis_tvalid <= 1'b1;
					void'(pending_reqs.pop_front());
					gap_left <= no_gaps ? 0 : $urandom_range(0, 11);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each transfer, then draw the next stall
	always @(posedge clk or negedge arst_n) begin
		alloc_resp_t e;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_allocs.size() == 0) begin
					report("unexpected result", m_axis_tdata[31:0], '0);
				end else begin
					e = expected_allocs.pop_front();
					if (m_axis_tdata[31:0] !== e.addr) report("block_addr", m_axis_tdata[31:0], e.addr);
					if (m_axis_tdata[33:32] !== e.status)
						report("status", m_axis_tdata[33:32], e.status);
					if (m_axis_tdata[64:34] !== e.grown)
						report("grow_bytes", m_axis_tdata[64:34], e.grown);
				end
			end
			if (long_hold_req && hold_left == 0 && m_axis_tready) begin
				hold_left <= LONG_HOLD;
				m_axis_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= (hold_left == 1);
			end else if (m_axis_tvalid && m_axis_tready && !no_gaps) begin
				hold_left <= $urandom_range(0, 11);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic cfg_write(logic idx, logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_INITIAL_GROW_EXP) sh_init_exp = value[EXP_W-1:0];
		else sh_limit = value;
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || s_axis_tvalid || expected_allocs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic queue_req(logic [REQ_W-1:0] size, bit drain_first = 1'b0);
		alloc_req_t r;
		r.size = size;
		r.drain_first = drain_first;
		pending_reqs.push_back(r);
	endtask

	function automatic logic [REQ_W-1:0] random_size();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) return REQ_W'($urandom_range(0, 255));
		if (pick < 92) return REQ_W'($urandom_range(0, 65535));
		return REQ_W'($urandom());
	endfunction

	initial begin
		int phase, n;
		logic [31:0] lim;
		for (int k = 0; k < FREE_SLOTS; k++) begin
			sh_size[k] = '0;
			sh_start[k] = '0;
			sh_next[k] = 0;
			sh_prev[k] = 0;
		end
		sh_head = FREE_SLOTS;
		sh_exp = 0;
		sh_top = '0;
		sh_started = 1'b0;
		sh_init_exp = 8;
		sh_limit = '1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Smallest first block, then exact fits, growth and extreme sizes
		cfg_write(CFG_INITIAL_GROW_EXP, 4);
		cfg_write(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
		queue_req(8);
		queue_req(1);
		queue_req(15);
		queue_req(0);
		queue_req(24'hFF_FFFF);
		queue_req(24'hAA_AAAA);
		queue_req(24'h55_5555);
		queue_req(24'h80_0000);
		queue_req(2);
		queue_req(7);
		wait_idle();

		// Limit just past the top: free-list hits still work, growth runs out
		cfg_write(CFG_HEAP_LIMIT, sh_top + 100);
		queue_req(50);
		queue_req(24'hFF_FFFF);
		queue_req(3);
		wait_idle();
		cfg_write(CFG_HEAP_LIMIT, 32'h0);
		queue_req(24'h10_0000);
		queue_req(0);
		wait_idle();
		cfg_write(CFG_INITIAL_GROW_EXP, 31);
		cfg_write(CFG_INITIAL_GROW_EXP, 30);
		cfg_write(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);

		// Random phases over several settings
		for (phase = 0; phase < 6; phase++) begin
			no_gaps = (phase == 2);
			case (phase % 3)
				0: lim = 32'hFFFF_FFFF;
				1: lim = sh_top + $urandom_range(0, 1 << 20);
				default: lim = $urandom();
			endcase
			cfg_write(CFG_INITIAL_GROW_EXP, $urandom_range(4, 31));
			cfg_write(CFG_HEAP_LIMIT, lim);
			for (n = 0; n < 190; n++)
				queue_req(random_size(), n == 95);
			if (phase == 3) begin
				while (pending_reqs.size() > 150) @(posedge clk);
				// hold the request until the long stall has begun
				long_hold_req = 1'b1;
				wait (hold_left > 11);
				long_hold_req = 1'b0;
			end
			wait_idle();
		end

		repeat (50) @(posedge clk);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
